[hw/rtl/ptms_pkg.sv]
`timescale 1ns / 1ps
package ptms_pkg;

   localparam int ADDR_W = 48;

   localparam logic [1:0] KIND_BOND   = 2'd0;
   localparam logic [1:0] KIND_OBS    = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [1:0] ROLE_UNKNOWN  = 2'd0;
   localparam logic [1:0] ROLE_PHYSICAL = 2'd1;
   localparam logic [1:0] ROLE_LINK     = 2'd2;
   localparam logic [1:0] ROLE_MGMT     = 2'd3;

   localparam logic [7:0] NO_SLOT = 8'hFF;
   localparam logic [7:0] NO_TYPE = 8'hFF;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] address;
      logic [1:0]        transport;
      logic [6:0]        le_slot;
      logic [7:0]        le_atype;
      logic [7:0]        bredr_key;
      logic [3:0]        role_flags;
      logic              connected;
      logic [15:0]       vend_id;
      logic [15:0]       prod_id;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] peer_address;
      logic [1:0]        peer_transport;
      logic signed [7:0] peer_le_slot;
      logic [7:0]        peer_le_atype;
      logic [7:0]        peer_bredr_key;
      logic [1:0]        peer_role;
      logic              peer_connected;
      logic [15:0]       peer_vend_id;
      logic [15:0]       peer_prod_id;
      logic              entry_valid;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [1:0]        transport;
      logic [7:0]        le_slot;
      logic [7:0]        le_type;
      logic [7:0]        key_type;
      logic [1:0]        role;
      logic              conn;
      logic [15:0]       vid;
      logic [15:0]       pid;
   } row_type;

   function automatic logic [1:0] role_of(input logic [3:0] flags);
      logic [1:0] r;
      if (flags[0])                r = ROLE_MGMT;
      else if (flags[1])           r = ROLE_LINK;
      else if (flags[2] | flags[3]) r = ROLE_PHYSICAL;
      else                         r = ROLE_UNKNOWN;
      return r;
   endfunction

   function automatic row_type fresh_row(input logic [ADDR_W-1:0] addr);
      row_type r;
      r          = '0;
      r.addr     = addr;
      r.le_slot  = NO_SLOT;
      r.le_type  = NO_TYPE;
      r.key_type = NO_TYPE;
      return r;
   endfunction

   function automatic row_type merge_item(input row_type row, input req_type item);
      row_type    r;
      logic [1:0] role;
      r    = row;
      role = role_of(item.role_flags);
      if (item.kind == KIND_BOND) begin
         r.transport = row.transport | item.transport;
         if (item.transport[0]) begin
            r.le_slot = {1'b0, item.le_slot};
            r.le_type = item.le_atype;
         end
         if (item.transport[1]) begin
            r.key_type = item.bredr_key;
         end
      end else begin
         if (role > row.role) begin
            r.role = role;
         end
         if (item.connected) begin
            r.conn = 1'b1;
         end
         if (row.vid == 16'd0 && row.pid == 16'd0) begin
            r.vid = item.vend_id;
            r.pid = item.prod_id;
         end
      end
      return r;
   endfunction

   function automatic rsp_type row_to_rsp(input row_type row, input logic last);
      rsp_type o;
      o.peer_address   = row.addr;
      o.peer_transport = row.transport;
      o.peer_le_slot   = row.le_slot;
      o.peer_le_atype  = row.le_type;
      o.peer_bredr_key = row.key_type;
      o.peer_role      = row.role;
      o.peer_connected = row.conn;
      o.peer_vend_id   = row.vid;
      o.peer_prod_id   = row.pid;
      o.entry_valid    = 1'b1;
      o.last           = last;
      return o;
   endfunction

endpackage

[hw/rtl/ptms_if.sv]
`timescale 1ns / 1ps
interface ptms_req_if import ptms_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ptms_rsp_if import ptms_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/peer_table_merge_sorted.sv]
`timescale 1ns / 1ps
// bond / observation: stored addresses are read (LOOK) and compared (MATCH), then the row
// is written (NEW, UPDATE); when the table is full a new address is dropped
// the search uses one address comparator and one registered table read port
// finish with n entries: n passes, each scanning all n entries (SCAN, PICK), one result per
// pass, each held until its transfer; an empty table shows its single result in the cycle after the input transfer
// reset empties the table at once (entry count cleared); no clearing pass is needed
module peer_table_merge_sorted import ptms_pkg::*; #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   ptms_req_if.sink   req_chan,
   ptms_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_LOOK   = 8'b00000010,
      ST_MATCH  = 8'b00000100,
      ST_NEW    = 8'b00001000,
      ST_UPDATE = 8'b00010000,
      ST_SCAN   = 8'b00100000,
      ST_EMIT   = 8'b01000000,
      ST_PICK   = 8'b10000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              stopped_ff, stopped_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     done_ff, done_in;
   logic              prev_vld_ff, prev_vld_in;
   logic              best_vld_ff, best_vld_in;
   logic [ADDR_W-1:0] prev_ff, prev_in;
   req_type           item_ff, item_in;
   row_type           row_ff, row_in;
   row_type           best_ff, best_in;
   rsp_type           rsp_ff, rsp_in;
   row_type           rd_ff;
   row_type           mem_q [TABLE_DEPTH];

   logic              wr_en;
   logic              idx_at_end;
   logic              take;
   row_type           best_next;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = (state_ff == ST_EMIT);
   assign rsp_chan.data  = rsp_ff;

   assign idx_at_end = (idx_ff + CW'(1)) == count_ff;
   // sort pass keeps the smallest address above the one last sent
   assign take       = (!prev_vld_ff || rd_ff.addr > prev_ff) &&
                       (!best_vld_ff || rd_ff.addr < best_ff.addr);
   assign best_next  = take ? rd_ff : best_ff;
   assign wr_en      = (state_ff == ST_UPDATE);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[idx_ff[IW-1:0]] <= merge_item(row_ff, item_ff);
      end
      rd_ff <= mem_q[idx_ff[IW-1:0]];
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      stopped_in  = stopped_ff;
      idx_in      = idx_ff;
      done_in     = done_ff;
      prev_vld_in = prev_vld_ff;
      best_vld_in = best_vld_ff;
      prev_in     = prev_ff;
      item_in     = item_ff;
      row_in      = row_ff;
      best_in     = best_ff;
      rsp_in      = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               item_in     = req_chan.data;
               idx_in      = '0;
               done_in     = '0;
               prev_vld_in = 1'b0;
               best_vld_in = 1'b0;
               if (req_chan.data.kind == KIND_FINISH) begin
                  if (count_ff == '0) begin
                     rsp_in       = '0;
                     rsp_in.last  = 1'b1;
                     state_in     = ST_EMIT;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else if (req_chan.data.kind == KIND_OBS ||
                            (req_chan.data.kind == KIND_BOND && !stopped_ff)) begin
                  state_in = (count_ff == '0) ? ST_NEW : ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            state_in = ST_MATCH;
         end
         ST_MATCH: begin
            if (rd_ff.addr == item_ff.address) begin
               row_in   = rd_ff;
               state_in = ST_UPDATE;
            end else if (idx_at_end) begin
               state_in = ST_NEW;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_LOOK;
            end
         end
         ST_NEW: begin
            if (count_ff == CW'(TABLE_DEPTH)) begin
               if (item_ff.kind == KIND_BOND) begin
                  stopped_in = 1'b1;
               end
               state_in = ST_IDLE;
            end else begin
               row_in   = fresh_row(item_ff.address);
               idx_in   = count_ff;
               count_in = count_ff + CW'(1);
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            // table read in flight
            state_in = ST_PICK;
         end
         ST_PICK: begin
            best_in     = best_next;
            best_vld_in = best_vld_ff | take;
            if (idx_at_end) begin
               rsp_in   = row_to_rsp(best_next, (done_ff + CW'(1)) == count_ff);
               state_in = ST_EMIT;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_SCAN;
            end
         end
         ST_EMIT: begin
            if (rsp_chan.ready) begin
               if (rsp_ff.last) begin
                  count_in   = '0;
                  stopped_in = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  prev_in     = rsp_ff.peer_address;
                  prev_vld_in = 1'b1;
                  best_vld_in = 1'b0;
                  done_in     = done_ff + CW'(1);
                  idx_in      = '0;
                  state_in    = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         stopped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      done_ff     <= done_in;
      prev_vld_ff <= prev_vld_in;
      best_vld_ff <= best_vld_in;
      prev_ff     <= prev_in;
      item_ff     <= item_in;
      row_ff      <= row_in;
      best_ff     <= best_in;
      rsp_ff      <= rsp_in;
   end

endmodule

[hw/rtl/ptms_checker.sv]
`timescale 1ns / 1ps
module ptms_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_entry_valid,
   input logic rsp_last
);

   a_busy_excl: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("input taken while a result is pending");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |-> rsp_last)
      else $error("empty table result not marked last");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready)
      else $error("not ready after final transfer");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");

endmodule

bind peer_table_merge_sorted ptms_checker u_ptms_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_entry_valid (rsp_chan.data.entry_valid),
   .rsp_last        (rsp_chan.data.last)
);
